FILE: hdl/prq_pkg.sv
// Shared types and constants for the priority ready queue.
// No dependencies.
package prq_pkg;
	localparam int LevelsDef = 32;
	localparam int ThreadsDef = 128;
	localparam logic [7:0] ResetThreshold = 8'd100;

	typedef enum logic [1:0] {
		KIND_ENQ = 2'd0,
		KIND_MOVE = 2'd1,
		KIND_POP = 2'd2,
		KIND_NOP = 2'd3
	} kind_t;
endpackage

FILE: hdl/prq_if.sv
// Valid/ready channel interfaces for the priority ready queue.
// No dependencies; the widths are fixed in the declarations, not given as parameters.
interface prq_in_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [6:0] thread;
	logic [4:0] priority_req;
	logic [5:0] min_priority;
	modport source(output valid, kind, thread, priority_req, min_priority, input ready);
	modport sink(input valid, kind, thread, priority_req, min_priority, output ready);
endinterface

interface prq_out_if;
	logic valid;
	logic ready;
	logic [6:0] popped_thread;
	logic found;
	logic error;
	logic [7:0] queued_count;
	logic overloaded;
	modport source(output valid, popped_thread, found, error, queued_count, overloaded,
		input ready);
	modport sink(input valid, popped_thread, found, error, queued_count, overloaded,
		output ready);
endinterface

FILE: hdl/priority_ready_queue.sv
// Top level of the priority ready queue: sequencer, link memories, bitmap.
// Depends on prq_pkg, prq_if (prq_in_if, prq_out_if) and prq_ram.
//
//  channel  | dir | payload
//  in_ch    | in  | kind, thread, priority_req, min_priority
//  out_ch   | out | popped_thread, found, error, queued_count, overloaded
//  cfg      | in  | cfg_we / cfg_wdata (overload_threshold)
//
// After the accepting edge a nop, refused enqueue, pop miss or move of an unqueued
// thread runs ST_RD_T then ST_DONE; an enqueue adds a list link, a pop searches,
// reads the head and unlinks it, and a queued move unlinks then links anew. Each
// list access is an address cycle, a data cycle, then a write step. The result waits
// in an output register and the next item is taken in the cycle after the result beat.
// Per-thread levels sit in a memory with one written flag per thread, so an unwritten
// entry reads as level zero; queued flags are flip-flops cleared by arst_n.
module priority_ready_queue #(
	parameter int Levels = prq_pkg::LevelsDef,
	parameter int Threads = prq_pkg::ThreadsDef
) (
	input logic clk,
	input logic arst_n,
	prq_in_if.sink in_ch,
	prq_out_if.source out_ch,
	input logic cfg_we,
	input logic [7:0] cfg_wdata
);
	localparam int LW = $clog2(Levels);
	localparam int TW = $clog2(Threads);

	typedef enum logic [3:0] {
		ST_IDLE, ST_RD_T, ST_POP_SRCH, ST_POP_HD, ST_UNL_RD, ST_UNL, ST_UNL_W,
		ST_LNK_RD, ST_LNK, ST_LNK_W, ST_DONE
	} state_t;

	state_t state_q;
	logic [1:0] kind_q;
	logic [TW-1:0] t_q;
	logic [LW-1:0] nl_q;
	logic [5:0] minp_q;
	logic at_head_q;
	logic [Levels-1:0] mask_q;
	logic [Levels-1:0] lvl_queued_q;
	logic [Threads-1:0] lvw_q;
	logic [Threads-1:0] tq_q;
	logic [7:0] count_q;
	logic [7:0] thr_q;
	logic [LW-1:0] lvl_q;
	logic [TW-1:0] hd_q, tl_q, nx_q, pv_q;
	logic [TW-1:0] out_thread_q;
	logic out_found_q, out_err_q, out_valid_q;

	// memory ports
	logic hd_we, tl_we, nx_we, pv_we, tv_we;
	logic [LW-1:0] hd_wa, tl_wa, lv_ra;
	logic [TW-1:0] hd_wd, tl_wd, nx_wa, nx_wd, pv_wa, pv_wd, tr_ra, tv_ra;
	logic [TW-1:0] hd_rd, tl_rd, nx_rd, pv_rd;
	logic [LW-1:0] tv_rd, tlv_cur;

	prq_ram #(.Depth(Levels), .Width(TW)) u_head (.clk, .we(hd_we), .waddr(hd_wa),
		.wdata(hd_wd), .raddr(lv_ra), .rdata(hd_rd));
	prq_ram #(.Depth(Levels), .Width(TW)) u_tail (.clk, .we(tl_we), .waddr(tl_wa),
		.wdata(tl_wd), .raddr(lv_ra), .rdata(tl_rd));
	prq_ram #(.Depth(Threads), .Width(TW)) u_next (.clk, .we(nx_we), .waddr(nx_wa),
		.wdata(nx_wd), .raddr(tr_ra), .rdata(nx_rd));
	prq_ram #(.Depth(Threads), .Width(TW)) u_prev (.clk, .we(pv_we), .waddr(pv_wa),
		.wdata(pv_wd), .raddr(tr_ra), .rdata(pv_rd));
	prq_ram #(.Depth(Threads), .Width(LW)) u_tlev (.clk, .we(tv_we), .waddr(t_q),
		.wdata(nl_q), .raddr(tv_ra), .rdata(tv_rd));

	// thread level: read with the accepted thread id, valid in ST_RD_T
	assign tv_ra = (state_q == ST_IDLE) ? TW'(in_ch.thread) : t_q;
	assign tlv_cur = lvw_q[t_q] ? tv_rd : '0;
	assign tv_we = (prq_pkg::kind_t'(kind_q) == prq_pkg::KIND_MOVE) &&
		(((state_q == ST_RD_T) && !tq_q[t_q]) || (state_q == ST_UNL_W));

	// highest set level at or above the minimum
	logic pop_hit;
	logic [LW-1:0] pop_lvl;
	always_comb begin
		pop_hit = 1'b0;
		pop_lvl = '0;
		for (int i = 0; i < Levels; i++) begin
			if (mask_q[i] && (7'(i) >= {1'b0, minp_q})) begin
				pop_hit = 1'b1;
				pop_lvl = LW'(i);
			end
		end
	end

	logic in_fire, out_fire;
	assign in_fire = in_ch.valid && in_ch.ready;
	assign out_fire = out_valid_q && out_ch.ready;
	assign in_ch.ready = (state_q == ST_IDLE) && !out_valid_q;

	// clamp level request
	logic [LW-1:0] req_lvl;
	always_comb begin
		if (32'(in_ch.priority_req) >= Levels) begin
			req_lvl = LW'(Levels - 1);
		end else begin
			req_lvl = LW'(in_ch.priority_req);
		end
	end

	// read addresses and write-back of links
	always_comb begin
		lv_ra = lvl_q;
		tr_ra = t_q;
		hd_we = 1'b0; tl_we = 1'b0; nx_we = 1'b0; pv_we = 1'b0;
		hd_wa = lvl_q; tl_wa = lvl_q; hd_wd = t_q; tl_wd = t_q;
		nx_wa = t_q; nx_wd = t_q; pv_wa = t_q; pv_wd = t_q;
		case (state_q)
			ST_UNL_W: begin
				if (hd_q == t_q) begin
					if (tl_q != t_q) begin
						hd_we = 1'b1;
						hd_wd = nx_q;
					end
				end else begin
					nx_we = 1'b1;
					nx_wa = pv_q;
					nx_wd = nx_q;
					if (tl_q == t_q) begin
						tl_we = 1'b1;
						tl_wd = pv_q;
					end else begin
						pv_we = 1'b1;
						pv_wa = nx_q;
						pv_wd = pv_q;
					end
				end
			end
			ST_LNK_W: begin
				if (!mask_q[lvl_q]) begin
					hd_we = 1'b1;
					tl_we = 1'b1;
				end else if (at_head_q) begin
					pv_we = 1'b1; pv_wa = hd_q; pv_wd = t_q;
					nx_we = 1'b1; nx_wa = t_q; nx_wd = hd_q;
					hd_we = 1'b1;
				end else begin
					nx_we = 1'b1; nx_wa = tl_q; nx_wd = t_q;
					pv_we = 1'b1; pv_wa = t_q; pv_wd = tl_q;
					tl_we = 1'b1;
				end
			end
			default: ;
		endcase
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			mask_q <= '0;
			tq_q <= '0;
			lvw_q <= '0;
			count_q <= '0;
			thr_q <= prq_pkg::ResetThreshold;
			out_valid_q <= 1'b0;
			lvl_queued_q <= '0;
		end else begin
			if (cfg_we) thr_q <= cfg_wdata;
			if (out_fire) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						kind_q <= in_ch.kind;
						t_q <= TW'(in_ch.thread);
						minp_q <= in_ch.min_priority;
						nl_q <= req_lvl;
						out_thread_q <= '0;
						out_found_q <= 1'b0;
						out_err_q <= 1'b0;
						state_q <= ST_RD_T;
					end
				end
				ST_RD_T: begin
					case (prq_pkg::kind_t'(kind_q))
						prq_pkg::KIND_ENQ: begin
							lvl_q <= tlv_cur;
							if (tq_q[t_q]) begin
								out_err_q <= 1'b1;
								state_q <= ST_DONE;
							end else begin
								at_head_q <= 1'b0;
								state_q <= ST_LNK_RD;
							end
						end
						prq_pkg::KIND_MOVE: begin
							lvl_q <= tlv_cur;
							at_head_q <= tlv_cur > nl_q;
							if (tq_q[t_q]) begin
								state_q <= ST_UNL_RD;
							end else begin
								lvw_q[t_q] <= 1'b1;
								state_q <= ST_DONE;
							end
						end
						prq_pkg::KIND_POP: begin
							if (pop_hit && !minp_q[5]) begin
								lvl_q <= pop_lvl;
								state_q <= ST_POP_SRCH;
							end else begin
								state_q <= ST_DONE;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				// head address of the popped level goes out here
				ST_POP_SRCH: state_q <= ST_POP_HD;
				ST_POP_HD: begin
					t_q <= hd_rd;
					state_q <= ST_UNL_RD;
				end
				// level and thread addresses go out; data is latched in ST_UNL
				ST_UNL_RD: state_q <= ST_UNL;
				ST_UNL: state_q <= ST_UNL_W;
				ST_UNL_W: begin
					if (hd_q == t_q && tl_q == t_q) mask_q[lvl_q] <= 1'b0;
					if (prq_pkg::kind_t'(kind_q) == prq_pkg::KIND_POP) begin
						tq_q[t_q] <= 1'b0;
						if (count_q != 8'd0) count_q <= count_q - 8'd1;
						out_thread_q <= t_q;
						out_found_q <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						lvw_q[t_q] <= 1'b1;
						lvl_q <= nl_q;
						state_q <= ST_LNK_RD;
					end
				end
				ST_LNK_RD: state_q <= ST_LNK;
				ST_LNK: state_q <= ST_LNK_W;
				ST_LNK_W: begin
					mask_q[lvl_q] <= 1'b1;
					if (prq_pkg::kind_t'(kind_q) == prq_pkg::KIND_ENQ) begin
						tq_q[t_q] <= 1'b1;
						if (count_q != 8'hFF) count_q <= count_q + 8'd1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					out_valid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
			lvl_queued_q <= mask_q;
		end
	end

	// latch memory read data in the state after its address goes out
	always_ff @(posedge clk) begin
		if (state_q == ST_UNL || state_q == ST_LNK) begin
			hd_q <= hd_rd;
			tl_q <= tl_rd;
			nx_q <= nx_rd;
			pv_q <= pv_rd;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.popped_thread = 7'(out_thread_q);
	assign out_ch.found = out_found_q;
	assign out_ch.error = out_err_q;
	assign out_ch.queued_count = count_q;
	assign out_ch.overloaded = count_q >= thr_q;

	// no new beat while a result is pending
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !in_ch.ready) else $error("accept while result pending");
	// a found result never also carries the error flag
	a_found_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_found_q) |-> !out_err_q) else $error("found with error");
	// the last set level bit only clears by unlink
	a_mask_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(lvl_queued_q != '0 && mask_q == '0) |-> $past(state_q == ST_UNL_W))
		else $error("mask cleared outside unlink");
endmodule

FILE: hdl/prq_ram.sv
// Simple one-write, one-read synchronous memory with registered read data.
// No dependencies.
module prq_ram #(
	parameter int Depth = 128,
	parameter int Width = 7
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
